// ===== rtl/ceb_pkg.sv =====
package ceb_pkg;

    localparam int TIME_W    = 50;
    localparam int WIN_W     = 32;
    localparam int THR_W     = 16;
    localparam int E_W       = 16;
    localparam int PRIO_W    = 8;
    localparam int MOD_W     = 4;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FISSION_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONLY_FISSION = 2'd2;

    localparam logic [WIN_W-1:0] TIME_WINDOW_RST = 32'd1000000;
    localparam logic [THR_W-1:0] FISSION_THR_RST = 16'd1500;

    // opcodes
    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // module numbers with a meaning of their own
    localparam logic [MOD_W-1:0] MOD_SI_FRONT  = 4'd0;
    localparam logic [MOD_W-1:0] MOD_SI_BACK   = 4'd1;
    localparam logic [MOD_W-1:0] MOD_GAMMA_HI  = 4'd4;
    localparam logic [MOD_W-1:0] MOD_NEUTRON_HI = 4'd9;

    typedef enum logic [2:0] {
        CLS_FRONT,
        CLS_BACK,
        CLS_GAMMA,
        CLS_NEUTRON,
        CLS_OTHER
    } cls_t;

    // decoded input transaction
    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] t;
        cls_t              cls;
        logic              trig;
        logic [PRIO_W-1:0] prio;
        logic [E_W-1:0]    energy;
    } item_t;

    // one buffered hit
    typedef struct packed {
        logic [TIME_W-1:0] t;
        cls_t              cls;
        logic              trig;
        logic [PRIO_W-1:0] prio;
        logic [E_W-1:0]    energy;
    } hit_t;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [PRIO_W-1:0] id;
        logic [CNT_W-1:0]  nf;
        logic [CNT_W-1:0]  nb;
        logic [CNT_W-1:0]  ns;
        logic [CNT_W-1:0]  ng;
        logic [CNT_W-1:0]  nn;
        logic              fis;
        logic              trunc;
    } res_t;

    // engine to output stage
    typedef struct packed {
        logic res_valid;
        logic item_end;
    } out_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TO_CHECK,
        ST_EV_SCAN,
        ST_PQ_CHECK,
        ST_WRITE,
        ST_FLUSH,
        ST_DONE,
        ST_C_START,
        ST_C_HEADW,
        ST_C_SCAN,
        ST_C_FIN
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_SAT) ? c + CNT_W'(1) : COUNT_SAT;
    endfunction

endpackage

// ===== rtl/ceb_front.sv =====
module ceb_front
    import ceb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [TIME_W-1:0] hit_time,
    input  logic [MOD_W-1:0]  hit_module,
    input  logic              trigger_flag,
    input  logic [PRIO_W-1:0] trigger_priority,
    input  logic [E_W-1:0]    hit_energy,
    output logic              q_valid,
    output item_t             q_item,
    input  logic              q_pop
);

    item_t      buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      dec;
    cls_t       cls;

    // classify module number
    always_comb
    begin
        if (hit_module == MOD_SI_FRONT)
            cls = CLS_FRONT;
        else if (hit_module == MOD_SI_BACK)
            cls = CLS_BACK;
        else if (hit_module <= MOD_GAMMA_HI)
            cls = CLS_GAMMA;
        else if (hit_module <= MOD_NEUTRON_HI)
            cls = CLS_NEUTRON;
        else
            cls = CLS_OTHER;
    end

    assign dec = '{op: opcode, t: hit_time, cls: cls, trig: trigger_flag,
                   prio: trigger_priority, energy: hit_energy};

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];

    // two-entry transaction queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= dec;
    end

endmodule

// ===== rtl/ceb_engine.sv =====
module ceb_engine
    import ceb_pkg::*;
#(
    parameter int HIT_DEPTH     = 64,
    parameter int PENDING_DEPTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIN_W-1:0] time_window,
    input  logic [THR_W-1:0] fission_threshold,
    input  logic             only_fission,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    input  logic             out_ready,
    output out_ctl_t         ctl,
    output res_t             res
);

    localparam int HA_W = $clog2(HIT_DEPTH);
    localparam int HF_W = $clog2(HIT_DEPTH + 1);
    localparam int PA_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PF_W = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W = TIME_W + 1;

    // hit ring memory
    hit_t            mem [HIT_DEPTH];
    hit_t            rd_data_reg;
    logic [HA_W-1:0] rd_addr;

    // pending trigger queue: ring slot plus copies of time and priority
    logic [HA_W-1:0]   p_slot_reg [PENDING_DEPTH];
    logic [TIME_W-1:0] p_time_reg [PENDING_DEPTH];
    logic [PRIO_W-1:0] p_prio_reg [PENDING_DEPTH];
    logic [PF_W-1:0]   pfill_reg;

    state_t state_reg, state_next, ret_reg;
    item_t  cur_reg;
    logic [HA_W-1:0] head_reg;
    logic [HF_W-1:0] fill_reg;
    logic [PF_W-1:0] k_reg;
    logic [PF_W-1:0] ck_reg;
    logic            force_reg;
    logic [TIME_W-1:0] tt_reg;
    logic [PRIO_W-1:0] pr_reg;
    logic [HA_W-1:0]   scan_i_reg;
    logic [CNT_W-1:0]  nf_reg, nb_reg, ns_reg, ng_reg, nn_reg;
    logic [E_W-1:0]    fmax_reg, bmax_reg;
    logic              kill_reg, trunc_reg;

    logic [SUM_W-1:0] w_ext;
    logic             full, k_lt, p_full, expired, ev_hit, fis, emit;
    logic [SUM_W-1:0] p_t_plus_w, tt_plus_w, rd_t_plus_w;
    logic             in_win, last_scan;
    logic [PA_W-1:0]  k_idx, ck_idx;

    assign w_ext     = SUM_W'(time_window);
    assign full      = (fill_reg == HF_W'(HIT_DEPTH));
    assign k_lt      = (k_reg < pfill_reg);
    assign p_full    = (pfill_reg == PF_W'(PENDING_DEPTH));
    assign k_idx     = k_reg[PA_W-1:0];
    assign ck_idx    = ck_reg[PA_W-1:0];
    assign p_t_plus_w = SUM_W'(p_time_reg[k_idx]) + w_ext;
    assign expired    = p_t_plus_w < SUM_W'(cur_reg.t);
    assign ev_hit     = (p_slot_reg[k_idx] == head_reg);
    assign tt_plus_w  = SUM_W'(tt_reg) + w_ext;
    assign rd_t_plus_w = SUM_W'(rd_data_reg.t) + w_ext;
    assign in_win     = !(rd_t_plus_w < SUM_W'(tt_reg)) && !(SUM_W'(rd_data_reg.t) > tt_plus_w);
    assign last_scan  = ((HF_W'(scan_i_reg) + HF_W'(1)) == fill_reg);
    assign fis  = (nf_reg != '0) && (nb_reg != '0)
                  && (fmax_reg > fission_threshold) && (bmax_reg > fission_threshold);
    assign emit = !kill_reg && (!only_fission || fis);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = (q_item.op == OP_FLUSH) ? ST_FLUSH : ST_TO_CHECK;
            ST_TO_CHECK:
                if (k_lt)
                begin
                    if (expired)
                        state_next = ST_C_START;
                end
                else
                    state_next = full ? ST_EV_SCAN : ST_PQ_CHECK;
            ST_EV_SCAN:
                if (k_lt)
                begin
                    if (ev_hit)
                        state_next = ST_C_START;
                end
                else
                    state_next = ST_PQ_CHECK;
            ST_PQ_CHECK:
                state_next = (cur_reg.trig && p_full) ? ST_C_START : ST_WRITE;
            ST_WRITE:
                state_next = ST_DONE;
            ST_FLUSH:
                state_next = (pfill_reg != '0) ? ST_C_START : ST_DONE;
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            ST_C_START:
                state_next = ST_C_HEADW;
            ST_C_HEADW:
                state_next = (fill_reg == '0) ? ST_C_FIN : ST_C_SCAN;
            ST_C_SCAN:
                if (last_scan)
                    state_next = ST_C_FIN;
            ST_C_FIN:
                if (!emit || out_ready)
                    state_next = ret_reg;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop         = (state_reg == ST_IDLE) && q_valid;
        ctl.item_end  = (state_reg == ST_DONE) && out_ready;
        ctl.res_valid = (state_reg == ST_C_FIN) && emit && out_ready;
        case (state_reg)
            ST_C_START: rd_addr = head_reg;
            ST_C_HEADW: rd_addr = '0;
            ST_C_SCAN:  rd_addr = scan_i_reg + HA_W'(1);
            default:    rd_addr = head_reg;
        endcase
        res = '{t: tt_reg, id: pr_reg, nf: nf_reg, nb: nb_reg, ns: ns_reg,
                ng: ng_reg, nn: nn_reg, fis: fis, trunc: trunc_reg};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            pfill_reg <= '0;
            k_reg     <= '0;
            ck_reg    <= '0;
            force_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    k_reg <= '0;
                ST_TO_CHECK:
                    if (k_lt)
                    begin
                        if (expired)
                        begin
                            ck_reg    <= k_reg;
                            force_reg <= 1'b0;
                            ret_reg   <= ST_TO_CHECK;
                        end
                        else
                            k_reg <= k_reg + PF_W'(1);
                    end
                    else
                        k_reg <= '0;
                ST_EV_SCAN:
                    if (k_lt)
                    begin
                        if (ev_hit)
                        begin
                            ck_reg    <= k_reg;
                            force_reg <= 1'b1;
                            ret_reg   <= ST_PQ_CHECK;
                            k_reg     <= pfill_reg;
                        end
                        else
                            k_reg <= k_reg + PF_W'(1);
                    end
                ST_PQ_CHECK:
                    if (cur_reg.trig && p_full)
                    begin
                        ck_reg    <= '0;
                        force_reg <= 1'b1;
                        ret_reg   <= ST_WRITE;
                    end
                ST_WRITE:
                begin
                    if (cur_reg.trig && !p_full)
                        pfill_reg <= pfill_reg + PF_W'(1);
                    head_reg <= (HF_W'(head_reg) + HF_W'(1) >= HF_W'(HIT_DEPTH))
                                ? '0 : head_reg + HA_W'(1);
                    if (!full)
                        fill_reg <= fill_reg + HF_W'(1);
                end
                ST_FLUSH:
                    if (pfill_reg != '0)
                    begin
                        ck_reg    <= '0;
                        force_reg <= 1'b0;
                        ret_reg   <= ST_FLUSH;
                    end
                    else
                    begin
                        head_reg <= '0;
                        fill_reg <= '0;
                    end
                ST_C_FIN:
                    if (!emit || out_ready)
                        pfill_reg <= pfill_reg - PF_W'(1);
                default:
                    ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    cur_reg <= q_item;
            ST_WRITE:
                if (cur_reg.trig && !p_full)
                begin
                    p_slot_reg[pfill_reg[PA_W-1:0]] <= head_reg;
                    p_time_reg[pfill_reg[PA_W-1:0]] <= cur_reg.t;
                    p_prio_reg[pfill_reg[PA_W-1:0]] <= cur_reg.prio;
                end
            ST_C_START:
            begin
                tt_reg   <= p_time_reg[ck_idx];
                pr_reg   <= p_prio_reg[ck_idx];
                nf_reg   <= '0;
                nb_reg   <= '0;
                ns_reg   <= '0;
                ng_reg   <= '0;
                nn_reg   <= '0;
                fmax_reg <= '0;
                bmax_reg <= '0;
                kill_reg <= 1'b0;
            end
            ST_C_HEADW:
            begin
                // oldest hit still in window means history may be lost
                trunc_reg  <= force_reg || (full && (rd_t_plus_w >= SUM_W'(tt_reg)));
                scan_i_reg <= '0;
            end
            ST_C_SCAN:
            begin
                scan_i_reg <= scan_i_reg + HA_W'(1);
                if (in_win)
                begin
                    if (rd_data_reg.trig && (rd_data_reg.prio > pr_reg))
                        kill_reg <= 1'b1;
                    case (rd_data_reg.cls)
                        CLS_FRONT:
                        begin
                            nf_reg <= sat_inc(nf_reg);
                            ns_reg <= sat_inc(ns_reg);
                            if (rd_data_reg.energy > fmax_reg)
                                fmax_reg <= rd_data_reg.energy;
                        end
                        CLS_BACK:
                        begin
                            nb_reg <= sat_inc(nb_reg);
                            ns_reg <= sat_inc(ns_reg);
                            if (rd_data_reg.energy > bmax_reg)
                                bmax_reg <= rd_data_reg.energy;
                        end
                        CLS_GAMMA:   ng_reg <= sat_inc(ng_reg);
                        CLS_NEUTRON: nn_reg <= sat_inc(nn_reg);
                        default:     ;
                    endcase
                end
            end
            ST_C_FIN:
                if (!emit || out_ready)
                begin
                    // drop closed entry and compact the queue
                    for (int j = 0; j < PENDING_DEPTH - 1; j++)
                    begin
                        if (PF_W'(j) >= ck_reg)
                        begin
                            p_slot_reg[j] <= p_slot_reg[j + 1];
                            p_time_reg[j] <= p_time_reg[j + 1];
                            p_prio_reg[j] <= p_prio_reg[j + 1];
                        end
                    end
                end
            default:
                ;
        endcase
    end

    // ring memory port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            mem[head_reg] <= '{t: cur_reg.t, cls: cur_reg.cls, trig: cur_reg.trig,
                               prio: cur_reg.prio, energy: cur_reg.energy};
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== rtl/ceb_out.sv =====
module ceb_out
    import ceb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  out_ctl_t          ctl,
    input  res_t              res,
    output logic              out_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] event_time,
    output logic [PRIO_W-1:0] event_trigger_id,
    output logic [CNT_W-1:0]  si_front_count,
    output logic [CNT_W-1:0]  si_back_count,
    output logic [CNT_W-1:0]  si_count,
    output logic [CNT_W-1:0]  gamma_count,
    output logic [CNT_W-1:0]  neutron_count,
    output logic              fission_flag,
    output logic              truncated,
    output logic              last_of_run
);

    // one result is held back until it is known whether it is the last
    res_t hold_reg;
    logic hold_valid_reg, hold_valid_next;
    res_t obuf_reg;
    logic olast_reg;
    logic ov_reg, ov_next;
    logic out_free, load;

    assign out_free  = !ov_reg || !out_stall;
    assign out_ready = !hold_valid_reg || out_free;
    assign load      = hold_valid_reg && (ctl.res_valid || ctl.item_end);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        ov_next         = ov_reg && out_stall;
        if (ctl.res_valid)
            hold_valid_next = 1'b1;
        else if (ctl.item_end)
            hold_valid_next = 1'b0;
        if (load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obuf_reg  <= hold_reg;
            olast_reg <= ctl.item_end;
        end
        if (ctl.res_valid)
            hold_reg <= res;
    end

    assign out_valid        = ov_reg;
    assign event_time       = obuf_reg.t;
    assign event_trigger_id = obuf_reg.id;
    assign si_front_count   = obuf_reg.nf;
    assign si_back_count    = obuf_reg.nb;
    assign si_count         = obuf_reg.ns;
    assign gamma_count      = obuf_reg.ng;
    assign neutron_count    = obuf_reg.nn;
    assign fission_flag     = obuf_reg.fis;
    assign truncated        = obuf_reg.trunc;
    assign last_of_run      = olast_reg;

endmodule

// ===== rtl/coincidence_event_builder.sv =====
// Coincidence event builder: takes time-sorted hit transactions, buffers the last
// HIT_DEPTH hits in a ring and closes up to PENDING_DEPTH pending triggers into
// events. A two-entry input queue takes new transactions while the engine works.
// A hit runs a timeout scan over the pending triggers and, with a full ring, an
// overwrite check over them, then a check for a full pending queue and the write;
// closing a trigger scans every hit in the ring, which the window scan walks
// one hit a cycle through the single read port of the ring memory. A flush
// closes every pending trigger and then empties the ring. Results leave through
// a holding register, so the last result of a transaction carries last_of_run;
// a stalled result register holds the engine at its next result or at the end
// of the transaction.
module coincidence_event_builder
    import ceb_pkg::*;
#(
    parameter int HIT_DEPTH     = 64,
    parameter int PENDING_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 opcode,
    input  logic [TIME_W-1:0]    hit_time,
    input  logic [MOD_W-1:0]     hit_module,
    input  logic                 trigger_flag,
    input  logic [PRIO_W-1:0]    trigger_priority,
    input  logic [E_W-1:0]       hit_energy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TIME_W-1:0]    event_time,
    output logic [PRIO_W-1:0]    event_trigger_id,
    output logic [CNT_W-1:0]     si_front_count,
    output logic [CNT_W-1:0]     si_back_count,
    output logic [CNT_W-1:0]     si_count,
    output logic [CNT_W-1:0]     gamma_count,
    output logic [CNT_W-1:0]     neutron_count,
    output logic                 fission_flag,
    output logic                 truncated,
    output logic                 last_of_run
);

    logic [WIN_W-1:0] time_window_reg;
    logic [THR_W-1:0] fission_thr_reg;
    logic             only_fission_reg;

    logic     q_valid, q_pop, out_ready;
    item_t    q_item;
    out_ctl_t ctl;
    res_t     res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_window_reg  <= TIME_WINDOW_RST;
            fission_thr_reg  <= FISSION_THR_RST;
            only_fission_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIME_WINDOW:  time_window_reg  <= cfg_data;
                REG_FISSION_THR:  fission_thr_reg  <= cfg_data[THR_W-1:0];
                REG_ONLY_FISSION: only_fission_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    ceb_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .hit_time         (hit_time),
        .hit_module       (hit_module),
        .trigger_flag     (trigger_flag),
        .trigger_priority (trigger_priority),
        .hit_energy       (hit_energy),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    ceb_engine #(
        .HIT_DEPTH     (HIT_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .time_window       (time_window_reg),
        .fission_threshold (fission_thr_reg),
        .only_fission      (only_fission_reg),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .out_ready         (out_ready),
        .ctl               (ctl),
        .res               (res)
    );

    ceb_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .res              (res),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_time       (event_time),
        .event_trigger_id (event_trigger_id),
        .si_front_count   (si_front_count),
        .si_back_count    (si_back_count),
        .si_count         (si_count),
        .gamma_count      (gamma_count),
        .neutron_count    (neutron_count),
        .fission_flag     (fission_flag),
        .truncated        (truncated),
        .last_of_run      (last_of_run)
    );

endmodule

// ===== rtl/ceb_checker.sv =====
module ceb_checker
    import ceb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [CNT_W-1:0] si_front_count,
    input logic [CNT_W-1:0] si_back_count,
    input logic [CNT_W-1:0] si_count,
    input logic [CNT_W-1:0] gamma_count,
    input logic [CNT_W-1:0] neutron_count,
    input logic             fission_flag
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // silicon total covers both sides
    a_si_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (si_count >= si_front_count) && (si_count >= si_back_count))
        else $error("silicon total below a side count");

    // fission needs hits on both sides
    a_fis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fission_flag |-> (si_front_count != '0) && (si_back_count != '0))
        else $error("fission without both silicon sides");

    // multiplicities saturate
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (si_count <= COUNT_SAT) && (gamma_count <= COUNT_SAT)
                      && (neutron_count <= COUNT_SAT))
        else $error("count beyond saturation");

endmodule

bind coincidence_event_builder ceb_checker u_ceb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .si_front_count (si_front_count),
    .si_back_count  (si_back_count),
    .si_count       (si_count),
    .gamma_count    (gamma_count),
    .neutron_count  (neutron_count),
    .fission_flag   (fission_flag)
);
